// ===== hdl/jraf_pkg.sv =====
`timescale 1ns / 1ps

package jraf_pkg;

  // Item function codes.
  localparam logic [1:0] FUNC_CLEAR    = 2'd0;
  localparam logic [1:0] FUNC_APPEND   = 2'd1;
  localparam logic [1:0] FUNC_CLASSIFY = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BOUND_INTERFACE = 3'd0;
  localparam logic [2:0] CFG_PROMISCUOUS     = 3'd1;
  localparam logic [2:0] CFG_RECEIVE_OWN     = 3'd2;
  localparam logic [2:0] CFG_BOUND_NAME      = 3'd3;
  localparam logic [2:0] CFG_BOUND_ADDRESS   = 3'd4;

  localparam logic [7:0] LAST_UNICAST  = 8'd253;
  localparam logic [7:0] ADDR_RESET    = 8'd255;

  typedef struct packed {
    logic [1:0]  func;
    logic [17:0] pgn;
    logic [17:0] pgn_care;
    logic [7:0]  addr;
    logic [7:0]  addr_care;
    logic [63:0] name;
    logic [63:0] name_care;
    logic [63:0] dst_name;
    logic [7:0]  dst_addr;
    logic        dst_remote;
    logic        from_self;
    logic [7:0]  interface_req;
  } item_t;

  typedef struct packed {
    logic accept;
    logic confirm_own;
    logic table_full;
  } result_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] wdata;
  } cfg_write_t;

  typedef struct packed {
    logic [17:0] pgn;
    logic [17:0] pgn_bits;
    logic [7:0]  addr;
    logic [7:0]  addr_bits;
    logic [63:0] name;
    logic [63:0] name_bits;
  } filter_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic append;
    logic walk_init;
    logic walk_step;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       walk_done;
    logic       rd_pending;
    logic       out_free;
  } ctrl_status_t;

endpackage

// ===== hdl/jraf_ifs.sv =====
`timescale 1ns / 1ps

interface jraf_item_if;
  logic              valid;
  logic              ready;
  jraf_pkg::item_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jraf_result_if;
  logic              valid;
  logic              ready;
  jraf_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jraf_cfg_if;
  logic                 valid;
  logic                 ready;
  jraf_pkg::cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/jraf_ctrl.sv =====
`timescale 1ns / 1ps

module jraf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  jraf_pkg::ctrl_status_t sts,
  output jraf_pkg::ctrl_cmd_t    cmd
);
  import jraf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.func)
          FUNC_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = ST_RESP;
          end
          FUNC_APPEND: begin
            cmd.append = 1'b1;
            state_next = ST_RESP;
          end
          FUNC_CLASSIFY: begin
            cmd.walk_init = 1'b1;
            state_next    = ST_WALK;
          end
          default: begin
            state_next = ST_RESP;
          end
        endcase
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        // The last read's compare lands in the cycle after the final issue.
        if (sts.walk_done && !sts.rd_pending) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.clear, cmd.append, cmd.walk_init, cmd.walk_step, cmd.load}))
    else $error("more than one datapath command in a cycle");

  a_capture_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == ST_DECODE)
    else $error("captured item not decoded next cycle");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> item_ready)
    else $error("not ready after a result was loaded");

endmodule

// ===== hdl/jraf_datapath.sv =====
`timescale 1ns / 1ps

module jraf_datapath #(
  parameter int MAX_FILTERS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  jraf_pkg::ctrl_cmd_t    cmd,
  output jraf_pkg::ctrl_status_t sts,
  input  jraf_pkg::item_t        item_data,
  jraf_cfg_if.sink               cfg,
  jraf_result_if.source          result
);
  import jraf_pkg::*;

  localparam int CNT_W = $clog2(MAX_FILTERS + 1);
  localparam int IDX_W = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FILTERS);

  // Configuration registers.
  logic [7:0]  bound_interface;
  logic        promiscuous;
  logic        receive_own;
  logic [63:0] bound_name;
  logic [7:0]  bound_address;

  item_t            item_q;
  filter_t          mem [MAX_FILTERS];
  filter_t          rd_q;
  logic             rd_vld;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] idx;
  logic             hit;
  logic             full_flag;
  logic             ovalid;
  result_t          res_q;

  logic    tbl_full;
  logic    walk_done;
  logic    rd_match;
  logic    iface_ok;
  logic    dest_ok;
  logic    own_ok;
  filter_t wr_entry;
  result_t res_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_interface <= '0;
      promiscuous     <= 1'b0;
      receive_own     <= 1'b0;
      bound_name      <= '0;
      bound_address   <= ADDR_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_BOUND_INTERFACE: bound_interface <= cfg.data.wdata[7:0];
        CFG_PROMISCUOUS:     promiscuous     <= cfg.data.wdata[0];
        CFG_RECEIVE_OWN:     receive_own     <= cfg.data.wdata[0];
        CFG_BOUND_NAME:      bound_name      <= cfg.data.wdata;
        CFG_BOUND_ADDRESS:   bound_address   <= cfg.data.wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item_data;
    end
  end

  assign tbl_full  = (cnt == CNT_MAX);
  assign walk_done = (idx == cnt);

  always_comb begin
    wr_entry.pgn       = item_q.pgn;
    wr_entry.pgn_bits  = item_q.pgn_care;
    wr_entry.addr      = item_q.addr;
    wr_entry.addr_bits = item_q.addr_care;
    wr_entry.name      = item_q.name;
    wr_entry.name_bits = item_q.name_care;
  end

  // Filter table: one write port at the fill count, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.append && !tbl_full) begin
      mem[cnt[IDX_W-1:0]] <= wr_entry;
    end
    if (cmd.walk_step && !walk_done) begin
      rd_q <= mem[idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      idx    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt <= '0;
      end else if (cmd.append && !tbl_full) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.walk_init) begin
        idx    <= '0;
        rd_vld <= 1'b0;
      end else if (cmd.walk_step) begin
        rd_vld <= !walk_done;
        if (!walk_done) begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  assign rd_match = (((item_q.pgn ^ rd_q.pgn) & rd_q.pgn_bits) == '0) &&
                    (((item_q.addr ^ rd_q.addr) & rd_q.addr_bits) == '0) &&
                    (((item_q.name ^ rd_q.name) & rd_q.name_bits) == '0);

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      // An empty table matches every message.
      hit <= (cnt == '0);
    end else if (cmd.walk_step && rd_vld && rd_match) begin
      hit <= 1'b1;
    end
    if (cmd.capture) begin
      full_flag <= 1'b0;
    end else if (cmd.append) begin
      full_flag <= tbl_full;
    end
  end

  assign iface_ok = (bound_interface == '0) || (bound_interface == item_q.interface_req);

  always_comb begin
    if (promiscuous) begin
      dest_ok = 1'b1;
    end else if (item_q.dst_remote) begin
      dest_ok = 1'b0;
    end else if (bound_name != '0) begin
      dest_ok = (item_q.dst_name == '0) || (item_q.dst_name == bound_name);
    end else if (bound_address <= LAST_UNICAST) begin
      dest_ok = (item_q.dst_addr > LAST_UNICAST) || (item_q.dst_addr == bound_address);
    end else begin
      dest_ok = 1'b1;
    end
  end

  assign own_ok = !item_q.from_self || receive_own;

  always_comb begin
    res_next.accept      = (item_q.func == FUNC_CLASSIFY) && iface_ok && dest_ok &&
                           own_ok && hit;
    res_next.confirm_own = res_next.accept && item_q.from_self;
    res_next.table_full  = full_flag;
  end

  // Output register: holds a finished beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.load) begin
      ovalid <= 1'b1;
    end else if (result.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_q <= res_next;
    end
  end

  assign result.valid = ovalid;
  assign result.data  = res_q;

  always_comb begin
    sts.func       = item_q.func;
    sts.walk_done  = walk_done;
    sts.rd_pending = rd_vld;
    sts.out_free   = !ovalid || result.ready;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_MAX)
    else $error("filter count beyond table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> cnt == '0)
    else $error("clear did not empty the table");

  a_full_no_accept: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> !(res_q.table_full && res_q.accept))
    else $error("table full reported together with accept");

  a_own_needs_accept: assert property (@(posedge clk) disable iff (rst)
    ovalid && res_q.confirm_own |-> res_q.accept)
    else $error("confirm_own without accept");

endmodule

// ===== hdl/j1939_receive_acceptance_filter.sv =====
`timescale 1ns / 1ps
// Flow: an item is captured, then decoded; clear, append and unused codes go straight to the
// response state, while a classify first walks the n filters of the table and then responds.
// Throughput: one item at a time; the next item is taken the cycle after the result is
// loaded, so a classify occupies the block for longer as the filter walk grows with n.
// Reset (rst, synchronous) empties the table and restores the register reset values.
module j1939_receive_acceptance_filter #(
  parameter int MAX_FILTERS = 16
) (
  input logic           clk,
  input logic           rst,
  jraf_item_if.sink     item,
  jraf_result_if.source result,
  jraf_cfg_if.sink      cfg
);
  import jraf_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t sts;

  jraf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  jraf_datapath #(
    .MAX_FILTERS (MAX_FILTERS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .item_data (item.data),
    .cfg       (cfg),
    .result    (result)
  );

endmodule
